[hdl/sstvs1_pkg.sv]
// shared types, constants and tone tables for the scottie 1 tone sequencer
// no dependencies; used by every module under hdl

package sstvs1_pkg;

  // line store geometry and frame layout
  localparam int MAX_WIDTH    = 512;
  localparam int BANNER_LINES = 16;
  localparam int PIX_W        = $clog2(MAX_WIDTH);
  localparam int WCMP_W       = PIX_W + 1;
  localparam int LC_W         = 9;
  localparam int STORE_DEPTH  = 2 * MAX_WIDTH;

  // queue between front and back
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TONE  = 1'b1;

  // tone kinds and channels
  localparam logic       KIND_FIXED = 1'b0;
  localparam logic       KIND_PIXEL = 1'b1;
  localparam logic [1:0] CH_RED     = 2'd0;
  localparam logic [1:0] CH_GREEN   = 2'd1;
  localparam logic [1:0] CH_BLUE    = 2'd2;
  localparam logic [1:0] CH_NONE    = 2'd3;

  // register indexes
  localparam logic [1:0] REG_VIS_CODE    = 2'd0;
  localparam logic [1:0] REG_LINE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_LINES = 2'd2;

  localparam logic [6:0] VIS_CODE_RST    = 7'd60;
  localparam logic [9:0] LINE_WIDTH_RST  = 10'd320;
  localparam logic [7:0] IMAGE_LINES_RST = 8'd240;

  // fixed frequencies in hz
  localparam logic [11:0] F_BIT_ONE  = 12'd1100;
  localparam logic [11:0] F_BIT_ZERO = 12'd1300;
  localparam logic [11:0] F_SYNC     = 12'd1200;
  localparam logic [11:0] F_SEP      = 12'd1500;
  localparam logic [11:0] F_NONE     = 12'd0;

  // durations in microseconds
  localparam logic [18:0] DUR_PULSE = 19'd9000;
  localparam logic [18:0] DUR_PORCH = 19'd1500;
  localparam logic [18:0] DUR_SEP   = 19'd1500;
  localparam logic [18:0] DUR_SCAN  = 19'd432;
  localparam logic [18:0] DUR_BIT   = 19'd30000;

  localparam logic [3:0] HDR_LAST = 4'd11;
  localparam logic [3:0] VIS_LAST = 4'd6;

  typedef struct packed {
    logic        req_type;
    logic [8:0]  column;
    logic [15:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic        tone_kind;
    logic [11:0] freq_hz;
    logic [5:0]  level;
    logic [1:0]  channel;
    logic [18:0] duration_us;
    logic [8:0]  line_number;
    logic        line_start;
    logic        frame_end;
  } out_item_t;

  typedef struct packed {
    logic [6:0] vis_code;
    logic [9:0] line_width;
    logic [7:0] image_lines;
  } cfg_t;

  // classified item as it sits in the queue
  typedef struct packed {
    logic             is_tone;
    logic             wr_ok;
    logic [PIX_W-1:0] col;
    logic [15:0]      pixel;
  } q_entry_t;

  typedef enum logic [11:0] {
    SEC_HDR   = 12'b0000_0000_0001,
    SEC_VIS   = 12'b0000_0000_0010,
    SEC_PAR   = 12'b0000_0000_0100,
    SEC_STOP  = 12'b0000_0000_1000,
    SEC_FSYNC = 12'b0000_0001_0000,
    SEC_SEP1  = 12'b0000_0010_0000,
    SEC_GREEN = 12'b0000_0100_0000,
    SEC_SEP2  = 12'b0000_1000_0000,
    SEC_BLUE  = 12'b0001_0000_0000,
    SEC_SYNC  = 12'b0010_0000_0000,
    SEC_PORCH = 12'b0100_0000_0000,
    SEC_RED   = 12'b1000_0000_0000
  } section_t;

  // vox and start tones of the frame header
  function automatic logic [11:0] hdr_freq(input logic [3:0] s);
    logic [11:0] f;
    unique case (s)
      4'd1, 4'd3, 4'd5, 4'd7: f = 12'd1500;
      4'd4, 4'd6:             f = 12'd2300;
      4'd9, 4'd11:            f = 12'd1200;
      default:                f = 12'd1900;
    endcase
    return f;
  endfunction

  function automatic logic [18:0] hdr_dur(input logic [3:0] s);
    logic [18:0] d;
    unique case (s)
      4'd8, 4'd10: d = 19'd300000;
      4'd9:        d = 19'd10000;
      4'd11:       d = 19'd30000;
      default:     d = 19'd100000;
    endcase
    return d;
  endfunction

endpackage

[hdl/sstvs1_front.sv]
// front end: accepts input items, classifies them and queues them for the back end
// depends on sstvs1_pkg

module sstvs1_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sstvs1_pkg::in_item_t  in_item,
  output logic                  head_valid,
  output sstvs1_pkg::q_entry_t  head,
  input  logic                  pop
);

  sstvs1_pkg::q_entry_t              q_mem_r [sstvs1_pkg::QUEUE_DEPTH];
  logic [sstvs1_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [sstvs1_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [sstvs1_pkg::QPTR_W:0]       count_r, count_nxt;
  sstvs1_pkg::q_entry_t              entry;
  logic                              push;
  logic                              do_pop;

  // classify
  always_comb begin
    entry.is_tone = (in_item.req_type == sstvs1_pkg::REQ_TONE);
    entry.wr_ok   = (int'(in_item.column) < sstvs1_pkg::MAX_WIDTH);
    entry.col     = sstvs1_pkg::PIX_W'(in_item.column);
    entry.pixel   = in_item.pixel;
  end

  assign in_stall   = (count_r == (sstvs1_pkg::QPTR_W+1)'(sstvs1_pkg::QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count_r != '0);
  assign head       = q_mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + sstvs1_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + sstvs1_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + (sstvs1_pkg::QPTR_W+1)'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - (sstvs1_pkg::QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (sstvs1_pkg::QPTR_W+1)'(sstvs1_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !do_pop |=> count_r == $past(count_r) + (sstvs1_pkg::QPTR_W+1)'(1))
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && !push |=> count_r == $past(count_r) - (sstvs1_pkg::QPTR_W+1)'(1))
    else $error("queue count missed a pop");

endmodule

[hdl/sstvs1_back.sv]
// back end: tone sequencer, double-banked line store and output register
// depends on sstvs1_pkg

module sstvs1_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sstvs1_pkg::cfg_t      cfg,
  input  logic                  head_valid,
  input  sstvs1_pkg::q_entry_t  head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sstvs1_pkg::out_item_t out_item
);

  sstvs1_pkg::section_t               section_r, section_nxt;
  logic [3:0]                         step_count_r, step_count_nxt;
  logic [sstvs1_pkg::PIX_W-1:0]       pixel_count_r, pixel_count_nxt;
  logic [sstvs1_pkg::LC_W-1:0]        line_count_r, line_count_nxt;
  logic                               parity_r, parity_nxt;
  logic                               scan_bank_r, scan_bank_nxt;

  logic [15:0]                        store_mem [sstvs1_pkg::STORE_DEPTH];
  logic [15:0]                        rd_data_r;

  logic                               out_valid_r;
  logic                               kind_r;
  logic [11:0]                        freq_r;
  logic [1:0]                         ch_r;
  logic [18:0]                        dur_r;
  logic [sstvs1_pkg::LC_W-1:0]        line_r;
  logic                               start_r;
  logic                               fend_r;

  logic                               res_kind;
  logic [11:0]                        res_freq;
  logic [1:0]                         res_ch;
  logic [18:0]                        res_dur;
  logic [sstvs1_pkg::LC_W-1:0]        res_line;
  logic                               res_start;
  logic                               res_fend;

  logic                               slot_free;
  logic                               tone_go;
  logic                               wr_en;
  logic [sstvs1_pkg::WCMP_W-1:0]      eff_w;
  logic                               last;
  logic [sstvs1_pkg::LC_W:0]          total;
  logic [7:0]                         img_eff;
  logic [3:0]                         hdr_s;
  logic [7:0]                         vis_ext;
  logic                               vis_bit;
  logic [5:0]                         level;

  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = head_valid && (!head.is_tone || slot_free);
  assign tone_go   = pop && head.is_tone;
  assign wr_en     = pop && !head.is_tone && head.wr_ok;

  // effective width and line total
  always_comb begin
    if (cfg.line_width == '0) begin
      eff_w = sstvs1_pkg::WCMP_W'(1);
    end else if (int'(cfg.line_width) > sstvs1_pkg::MAX_WIDTH) begin
      eff_w = sstvs1_pkg::WCMP_W'(sstvs1_pkg::MAX_WIDTH);
    end else begin
      eff_w = sstvs1_pkg::WCMP_W'(cfg.line_width);
    end
    img_eff = (cfg.image_lines == '0) ? 8'd1 : cfg.image_lines;
    total   = (sstvs1_pkg::LC_W+1)'(sstvs1_pkg::BANNER_LINES)
            + (sstvs1_pkg::LC_W+1)'(img_eff);
    last    = ({1'b0, pixel_count_r} + sstvs1_pkg::WCMP_W'(1)) >= eff_w;
    hdr_s   = (section_r == sstvs1_pkg::SEC_HDR && step_count_r <= sstvs1_pkg::HDR_LAST)
            ? step_count_r : 4'd0;
    vis_ext = {1'b0, cfg.vis_code};
    vis_bit = vis_ext[step_count_r[2:0]];
  end

  // sequencer
  always_comb begin
    section_nxt     = section_r;
    step_count_nxt  = step_count_r;
    pixel_count_nxt = pixel_count_r;
    line_count_nxt  = line_count_r;
    parity_nxt      = parity_r;
    scan_bank_nxt   = scan_bank_r;
    res_kind        = sstvs1_pkg::KIND_FIXED;
    res_freq        = sstvs1_pkg::F_SEP;
    res_ch          = sstvs1_pkg::CH_NONE;
    res_dur         = sstvs1_pkg::DUR_SEP;
    res_line        = line_count_r;
    res_start       = 1'b0;
    res_fend        = 1'b0;
    unique case (section_r)
      sstvs1_pkg::SEC_VIS: begin
        res_freq   = vis_bit ? sstvs1_pkg::F_BIT_ONE : sstvs1_pkg::F_BIT_ZERO;
        res_dur    = sstvs1_pkg::DUR_BIT;
        parity_nxt = parity_r ^ vis_bit;
        if (step_count_r >= sstvs1_pkg::VIS_LAST) begin
          section_nxt    = sstvs1_pkg::SEC_PAR;
          step_count_nxt = 4'd0;
        end else begin
          step_count_nxt = step_count_r + 4'd1;
        end
      end
      sstvs1_pkg::SEC_PAR: begin
        res_freq    = parity_r ? sstvs1_pkg::F_BIT_ONE : sstvs1_pkg::F_BIT_ZERO;
        res_dur     = sstvs1_pkg::DUR_BIT;
        section_nxt = sstvs1_pkg::SEC_STOP;
      end
      sstvs1_pkg::SEC_STOP: begin
        res_freq    = sstvs1_pkg::F_SYNC;
        res_dur     = sstvs1_pkg::DUR_BIT;
        section_nxt = sstvs1_pkg::SEC_FSYNC;
      end
      sstvs1_pkg::SEC_FSYNC: begin
        res_freq       = sstvs1_pkg::F_SYNC;
        res_dur        = sstvs1_pkg::DUR_PULSE;
        section_nxt    = sstvs1_pkg::SEC_SEP1;
        line_count_nxt = '0;
      end
      sstvs1_pkg::SEC_SEP1: begin
        scan_bank_nxt   = !scan_bank_r;
        res_start       = 1'b1;
        section_nxt     = sstvs1_pkg::SEC_GREEN;
        pixel_count_nxt = '0;
      end
      sstvs1_pkg::SEC_SEP2: begin
        section_nxt     = sstvs1_pkg::SEC_BLUE;
        pixel_count_nxt = '0;
      end
      sstvs1_pkg::SEC_SYNC: begin
        res_freq    = sstvs1_pkg::F_SYNC;
        res_dur     = sstvs1_pkg::DUR_PULSE;
        section_nxt = sstvs1_pkg::SEC_PORCH;
      end
      sstvs1_pkg::SEC_PORCH: begin
        res_dur         = sstvs1_pkg::DUR_PORCH;
        section_nxt     = sstvs1_pkg::SEC_RED;
        pixel_count_nxt = '0;
      end
      sstvs1_pkg::SEC_GREEN, sstvs1_pkg::SEC_BLUE, sstvs1_pkg::SEC_RED: begin
        res_kind = sstvs1_pkg::KIND_PIXEL;
        res_freq = sstvs1_pkg::F_NONE;
        res_dur  = sstvs1_pkg::DUR_SCAN;
        res_ch   = (section_r == sstvs1_pkg::SEC_GREEN) ? sstvs1_pkg::CH_GREEN
                 : (section_r == sstvs1_pkg::SEC_BLUE)  ? sstvs1_pkg::CH_BLUE
                 : sstvs1_pkg::CH_RED;
        res_fend = (section_r == sstvs1_pkg::SEC_RED) && last
                && (({1'b0, line_count_r} + (sstvs1_pkg::LC_W+1)'(1)) >= total);
        if (!last) begin
          pixel_count_nxt = pixel_count_r + sstvs1_pkg::PIX_W'(1);
        end else begin
          pixel_count_nxt = '0;
          if (section_r == sstvs1_pkg::SEC_GREEN) begin
            section_nxt = sstvs1_pkg::SEC_SEP2;
          end else if (section_r == sstvs1_pkg::SEC_BLUE) begin
            section_nxt = sstvs1_pkg::SEC_SYNC;
          end else if (res_fend) begin
            section_nxt    = sstvs1_pkg::SEC_HDR;
            step_count_nxt = 4'd0;
            line_count_nxt = '0;
          end else begin
            line_count_nxt = line_count_r + sstvs1_pkg::LC_W'(1);
            section_nxt    = sstvs1_pkg::SEC_SEP1;
          end
        end
      end
      default: begin
        // header tones, also the restart from any unknown section code
        line_count_nxt = '0;
        res_line       = '0;
        res_freq       = sstvs1_pkg::hdr_freq(hdr_s);
        res_dur        = sstvs1_pkg::hdr_dur(hdr_s);
        if (hdr_s >= sstvs1_pkg::HDR_LAST) begin
          section_nxt    = sstvs1_pkg::SEC_VIS;
          step_count_nxt = 4'd0;
          parity_nxt     = 1'b0;
        end else begin
          section_nxt    = sstvs1_pkg::SEC_HDR;
          step_count_nxt = hdr_s + 4'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_r     <= sstvs1_pkg::SEC_HDR;
      step_count_r  <= '0;
      pixel_count_r <= '0;
      line_count_r  <= '0;
      parity_r      <= 1'b0;
      scan_bank_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (tone_go) begin
        section_r     <= section_nxt;
        step_count_r  <= step_count_nxt;
        pixel_count_r <= pixel_count_nxt;
        line_count_r  <= line_count_nxt;
        parity_r      <= parity_nxt;
        scan_bank_r   <= scan_bank_nxt;
      end
      if (tone_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // line store: writes land in the fill bank, reads come from the scan bank
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[{!scan_bank_r, head.col}] <= head.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (tone_go) begin
      rd_data_r <= store_mem[{scan_bank_r, pixel_count_r}];
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (tone_go) begin
      kind_r  <= res_kind;
      freq_r  <= res_freq;
      ch_r    <= res_ch;
      dur_r   <= res_dur;
      line_r  <= res_line;
      start_r <= res_start;
      fend_r  <= res_fend;
    end
  end

  always_comb begin
    unique case (ch_r)
      sstvs1_pkg::CH_RED:   level = {1'b0, rd_data_r[15:11]};
      sstvs1_pkg::CH_GREEN: level = rd_data_r[10:5];
      sstvs1_pkg::CH_BLUE:  level = {1'b0, rd_data_r[4:0]};
      sstvs1_pkg::CH_NONE:  level = 6'd0;
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_item.tone_kind   = kind_r;
  assign out_item.freq_hz     = freq_r;
  assign out_item.level       = level;
  assign out_item.channel     = ch_r;
  assign out_item.duration_us = dur_r;
  assign out_item.line_number = 9'(line_r);
  assign out_item.line_start  = start_r;
  assign out_item.frame_end   = fend_r;

  a_tone_loads: assert property (@(posedge clk) disable iff (!rst_n)
    tone_go |=> out_valid_r)
    else $error("tone item left no result");

  a_fend_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && fend_r |-> kind_r == sstvs1_pkg::KIND_PIXEL && ch_r == sstvs1_pkg::CH_RED)
    else $error("frame end on a tone other than red pixel");

  a_start_sep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && start_r |-> kind_r == sstvs1_pkg::KIND_FIXED && freq_r == sstvs1_pkg::F_SEP)
    else $error("line start on a tone other than separator");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !head.is_tone && out_valid_r && out_stall |=> out_valid_r && $stable(kind_r))
    else $error("write item disturbed a waiting result");

endmodule

[hdl/sstv_scottie1_tone_sequencer_core.sv]
// top level of the scottie 1 sstv tone sequencer: config registers, front and back
// depends on sstvs1_pkg, sstvs1_front, sstvs1_back

// usage
//   in channel: in_valid/in_stall with in_item. req_type write stores the pixel
//   at column of the fill bank (columns past the store are dropped); req_type
//   tone asks for the next tone command of the frame.
//   out channel: out_valid/out_stall with out_item, one item per tone request
//   and none per write, in request order.
//   config: apb-style port, vis_code at 0x0, line_width at 0x4, image_lines at
//   0x8; write only while the block is idle. pready is tied high.
//   a tone request accepted on in passes through the queue and then the
//   output register before it shows on out_valid. throughput: one item per
//   cycle while out_stall stays low, set by the sequencer step and the one
//   read port of the line store.
//   a 4-entry queue sits between the classifying front and the sequencer; in
//   keeps flowing while a result waits in the output register, until the
//   queue fills and in_stall rises.
//   reset: section back to the frame header, counters and bank select
//   cleared, registers to their defaults; the line store is not cleared.
//   stall: a stalled result holds; writes behind it still drain from the queue until a tone request reaches its head.

module sstv_scottie1_tone_sequencer_core (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sstvs1_pkg::in_item_t  in_item,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output sstvs1_pkg::out_item_t out_item,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  sstvs1_pkg::cfg_t     cfg_r, cfg_nxt;
  logic                 cfg_wr;
  logic                 head_valid;
  sstvs1_pkg::q_entry_t head;
  logic                 pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register write decode, word index from paddr[3:2]
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        sstvs1_pkg::REG_VIS_CODE:    cfg_nxt.vis_code    = pwdata[6:0];
        sstvs1_pkg::REG_LINE_WIDTH:  cfg_nxt.line_width  = pwdata[9:0];
        sstvs1_pkg::REG_IMAGE_LINES: cfg_nxt.image_lines = pwdata[7:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vis_code    <= sstvs1_pkg::VIS_CODE_RST;
      cfg_r.line_width  <= sstvs1_pkg::LINE_WIDTH_RST;
      cfg_r.image_lines <= sstvs1_pkg::IMAGE_LINES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read back, low address bits ignored
  always_comb begin
    unique case (paddr[3:2])
      sstvs1_pkg::REG_VIS_CODE:    prdata = {25'd0, cfg_r.vis_code};
      sstvs1_pkg::REG_LINE_WIDTH:  prdata = {22'd0, cfg_r.line_width};
      sstvs1_pkg::REG_IMAGE_LINES: prdata = {24'd0, cfg_r.image_lines};
      default:                     prdata = 32'd0;
    endcase
  end

  // front: accept and classify, queue up to four items
  sstvs1_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // back: sequencer, line store and output register
  sstvs1_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("back end popped an empty queue");

  a_cfg_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && paddr[3:2] == sstvs1_pkg::REG_LINE_WIDTH |=> cfg_r.line_width == $past(pwdata[9:0]))
    else $error("line_width write lost");

  a_wait_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("waiting result dropped");

endmodule
